// File: hw/rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants for the timed trigger scheduler
// Item layouts for both channels, the stored slot record and the opcodes.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam logic [1:0] OP_BOOK  = 2'd0;
  localparam logic [1:0] OP_FIRE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // At most this many result items leave for one input item.
  localparam int MAX_RESULTS = 64;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        pad;
    logic [15:0]        velocity_code;
    logic [47:0]        at_sample;
    logic [12:0]        block_len;
    logic               is_release;
    logic               pan_valid;
    logic signed [15:0] pan_code;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_pad;
    logic [15:0]        out_velocity;
    logic [11:0]        offset;
    logic               out_release;
    logic               out_pan_valid;
    logic signed [15:0] out_pan;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [47:0]        sample;
    logic [15:0]        pad;
    logic [15:0]        velocity;
    logic               release_flag;
    logic               pan_given;
    logic signed [15:0] pan;
  } slot_t;

endpackage

// File: hw/rtl/tts_ram.sv
// ----------------------------------------------------------------------------
// tts_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/timed_trigger_scheduler_core.sv
// ----------------------------------------------------------------------------
// timed_trigger_scheduler_core: sample-accurate pad event scheduler
// Books trigger and release events, holds future ones in a slot store and
// releases them at the right offset when the audio block that holds them runs.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                         | Moves
//   --------+-------------------------------+--------------------------------
//   in      | in_valid, in_ready, in_data   | one command item (book/fire/clear)
//   out     | out_valid, out_ready, out_data| one scheduled event item
//
// A clear frees all slots and leaves the sequencer idle. A booking that falls
// inside the current block is emitted after its compare and offset clamp; a
// later booking searches the used bits one slot a cycle. A block op walks the
// slot store one slot per cycle while the out channel takes its items; every
// used slot adds a RAM read, a compare and an offset clamp, and the op closes
// with an end check and a flush. The slot RAM's single read port and the one
// shared subtract/compare unit set this pace. A stalled out channel holds the
// sequencer until it takes the item. Reset frees all slots at once and zeroes
// the block start.
// in_ready is high whenever the sequencer is idle, even while a finished
// result item still waits in the output register.
//
module timed_trigger_scheduler_core #(
  parameter int SLOTS     = 64,
  parameter int MAX_BLOCK = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tts_pkg::out_item_t out_data
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int LEN_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK + 1) : 1;
  localparam int SLOT_W = $bits(tts_pkg::slot_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_LOAD,
    S_CMP,
    S_OFF,
    S_BOOK,
    S_FLUSH
  } state_t;

  // Control state.
  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             idx_r, idx_nxt;
  logic [tts_pkg::RES_CNT_W-1:0] n_r, n_nxt;
  logic [SLOTS-1:0]             used_r, used_nxt;
  logic                         pend_v_r, pend_v_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [47:0]                  start_r, start_nxt;

  // Payload state.
  logic [1:0]                   op_r, op_nxt;
  logic [LEN_W-1:0]             len_r, len_nxt;
  logic [48:0]                  block_end_r, block_end_nxt;
  tts_pkg::slot_t               cand_r, cand_nxt;
  logic                         lt_r, lt_nxt;
  logic [48:0]                  diff_r, diff_nxt;
  tts_pkg::out_item_t           pend_r, pend_nxt;
  tts_pkg::out_item_t           out_r, out_nxt;

  // Slot RAM ports.
  logic                         ram_we, ram_re;
  logic [IDX_W-1:0]             addr;
  tts_pkg::slot_t               ram_wdata;
  logic [SLOT_W-1:0]            ram_rdata;

  // Helpers.
  logic                         out_free;
  logic [31:0]                  bl32, len32;
  logic [47:0]                  lim48, off48;
  tts_pkg::out_item_t           res;
  tts_pkg::slot_t               in_slot;
  logic                         in_pv;

  assign addr      = idx_r[IDX_W-1:0];
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign ram_wdata = cand_r;

  tts_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  // A zero block length counts as one sample; an oversized one is capped.
  always_comb begin
    bl32 = 32'(in_data.block_len);
    if (bl32 == 32'd0) begin
      len32 = 32'd1;
    end else if (bl32 > 32'(MAX_BLOCK)) begin
      len32 = 32'(MAX_BLOCK);
    end else begin
      len32 = bl32;
    end
  end

  // Releases drop velocity and pan; a missing pan reads as zero.
  always_comb begin
    in_pv                = in_data.pan_valid && !in_data.is_release;
    in_slot.sample       = in_data.at_sample;
    in_slot.pad          = in_data.pad;
    in_slot.velocity     = in_data.is_release ? 16'd0 : in_data.velocity_code;
    in_slot.release_flag = in_data.is_release;
    in_slot.pan_given    = in_pv;
    in_slot.pan          = in_pv ? in_data.pan_code : 16'sd0;
  end

  // Offset clamp: before the block start gives zero, past its end gives len-1.
  always_comb begin
    lim48 = 48'(len_r) - 48'd1;
    if (diff_r[48]) begin
      off48 = '0;
    end else if (diff_r[47:0] > lim48) begin
      off48 = lim48;
    end else begin
      off48 = diff_r[47:0];
    end
    res.out_pad       = cand_r.pad;
    res.out_velocity  = cand_r.velocity;
    res.offset        = off48[11:0];
    res.out_release   = cand_r.release_flag;
    res.out_pan_valid = cand_r.pan_given;
    res.out_pan       = cand_r.pan;
    res.last          = 1'b0;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    used_nxt      = used_r;
    pend_v_nxt    = pend_v_r;
    out_valid_nxt = out_valid_r && !out_ready;
    start_nxt     = start_r;
    op_nxt        = op_r;
    len_nxt       = len_r;
    block_end_nxt = block_end_r;
    cand_nxt      = cand_r;
    lt_nxt        = lt_r;
    diff_nxt      = diff_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_data.opcode;
          len_nxt       = len32[LEN_W-1:0];
          block_end_nxt = {1'b0, start_r} + 49'(len32[LEN_W-1:0]);
          cand_nxt      = in_slot;
          idx_nxt       = '0;
          n_nxt         = '0;
          case (in_data.opcode)
            tts_pkg::OP_BOOK:  state_nxt = S_CMP;
            tts_pkg::OP_FIRE:  state_nxt = S_RD;
            tts_pkg::OP_CLEAR: used_nxt  = '0;
            default:           state_nxt = S_IDLE;
          endcase
        end
      end

      // Walk the store; only used slots are read out of the RAM.
      S_RD: begin
        if (idx_r == CNT_W'(SLOTS) || n_r == tts_pkg::RES_CNT_W'(tts_pkg::MAX_RESULTS)) begin
          state_nxt = S_FLUSH;
        end else if (used_r[addr]) begin
          ram_re    = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_LOAD: begin
        cand_nxt  = tts_pkg::slot_t'(ram_rdata);
        state_nxt = S_CMP;
      end

      // The shared unit: due compare and distance from the block start.
      S_CMP: begin
        lt_nxt    = ({1'b0, cand_r.sample} < block_end_r);
        diff_nxt  = {1'b0, cand_r.sample} - {1'b0, start_r};
        state_nxt = S_OFF;
      end

      S_OFF: begin
        if (op_r == tts_pkg::OP_BOOK) begin
          if (!lt_r) begin
            state_nxt = S_BOOK;
          end else if (out_free) begin
            out_nxt       = res;
            out_nxt.last  = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (!lt_r) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end else if (!pend_v_r || out_free) begin
          // The newest due event waits in pend so that the final one of the
          // run can still be marked last when the walk ends.
          if (pend_v_r) begin
            out_nxt       = pend_r;
            out_valid_nxt = 1'b1;
          end
          pend_nxt       = res;
          pend_v_nxt     = 1'b1;
          used_nxt[addr] = 1'b0;
          n_nxt          = n_r + 1'b1;
          idx_nxt        = idx_r + 1'b1;
          state_nxt      = S_RD;
        end
      end

      // First free slot takes the booking; a full store emits at offset zero.
      S_BOOK: begin
        if (idx_r == CNT_W'(SLOTS)) begin
          if (out_free) begin
            out_nxt        = res;
            out_nxt.offset = '0;
            out_nxt.last   = 1'b1;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (!used_r[addr]) begin
          ram_we         = 1'b1;
          used_nxt[addr] = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_FLUSH: begin
        if (!pend_v_r) begin
          start_nxt = block_end_r[47:0];
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          pend_v_nxt    = 1'b0;
          start_nxt     = block_end_r[47:0];
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Payload registers carry no reset; control registers reset synchronously.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    len_r       <= len_nxt;
    block_end_r <= block_end_nxt;
    cand_r      <= cand_nxt;
    lt_r        <= lt_nxt;
    diff_r      <= diff_nxt;
    pend_r      <= pend_nxt;
    out_r       <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      n_r         <= '0;
      used_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      start_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      used_r      <= used_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
    end
  end

endmodule
